@@ design/pfb_pkg.sv @@
`timescale 1ns / 1ps
package pfb_pkg;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int SCREEN_ROWS    = SCREEN_PAGES * 8;
    localparam int STORE_DEPTH    = SCREEN_PAGES * SCREEN_COLUMNS;

    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int PAGE_W = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CRD_W  = 10;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] BLIT_MAX_BITS = 4'd8;
    localparam logic [2:0] PAGE_ROW_MASK = 3'h7;

    localparam logic [2:0] CMD_CLEAR = 3'd0;
    localparam logic [2:0] CMD_PIXEL = 3'd1;
    localparam logic [2:0] CMD_FILL  = 3'd2;
    localparam logic [2:0] CMD_BLIT  = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;

    localparam logic [2:0] OP_NOP   = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_DRAW  = 3'd2;
    localparam logic [2:0] OP_BLIT  = 3'd3;
    localparam logic [2:0] OP_READ  = 3'd4;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] width;
        logic [7:0] height;
        logic       color;
        logic [7:0] bitmap_bits;
        logic [3:0] bit_count;
        logic [2:0] page;
    } t_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       is_read;
    } t_result;

    typedef struct packed {
        logic [2:0]       op;
        logic [COL_W-1:0] col_lo;
        logic [COL_W-1:0] col_hi;
        logic [ROW_W-1:0] row_lo;
        logic [ROW_W-1:0] row_hi;
        logic             color;
        logic [7:0]       bits;
        logic             rd_ok;
    } t_cmd_desc;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

@@ design/page_frame_buffer_draw_engine_top.sv @@
`timescale 1ns / 1ps
// channel   direction  payload            handshake
// in        input      pfb_pkg::t_item    i_in_valid / o_in_stall
// out       output     pfb_pkg::t_result  o_out_valid / i_out_stall
//
// Clear writes every store byte, one store byte written per cycle; skipped commands go straight to the result.
// Pixel, fill and blit read and then write each touched byte, a read-modify-write
// on the single store port; an in-range read reads one byte.
// After reset all 1024 store bytes are swept to zero with o_in_stall high.
// A two-entry command queue lets the input side keep taking transfers while
// the result register waits on i_out_stall.
module page_frame_buffer_draw_engine_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pfb_pkg::t_item    i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pfb_pkg::t_result  o_out_item
);
    import pfb_pkg::*;

    logic         q_full;
    logic         q_empty;
    logic         push;
    logic         pop;
    t_cmd_desc    push_desc;
    t_cmd_desc    pop_desc;
    t_back_status status;

    pfb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_q_full    (q_full),
        .i_status    (status),
        .o_push      (push),
        .o_push_desc (push_desc)
    );

    pfb_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_desc (push_desc),
        .o_full      (q_full),
        .i_pop       (pop),
        .o_pop_desc  (pop_desc),
        .o_empty     (q_empty)
    );

    pfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_desc    (pop_desc),
        .o_pop       (pop),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

@@ design/pfb_front.sv @@
`timescale 1ns / 1ps
module pfb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  pfb_pkg::t_item       i_in_item,
    input  logic                 i_q_full,
    input  pfb_pkg::t_back_status i_status,
    output logic                 o_push,
    output pfb_pkg::t_cmd_desc   o_push_desc
);
    import pfb_pkg::*;

    localparam logic [CRD_W-1:0] COLS_C  = CRD_W'(SCREEN_COLUMNS);
    localparam logic [CRD_W-1:0] ROWS_C  = CRD_W'(SCREEN_ROWS);
    localparam logic [CRD_W-1:0] PAGES_C = CRD_W'(SCREEN_PAGES);
    localparam logic [CRD_W-1:0] COL_MAX = CRD_W'(SCREEN_COLUMNS - 1);
    localparam logic [CRD_W-1:0] ROW_MAX = CRD_W'(SCREEN_ROWS - 1);

    logic             r_stall;
    logic             n_stall;
    logic [CRD_W-1:0] x_c;
    logic [CRD_W-1:0] y_c;
    logic [CRD_W-1:0] x_end;
    logic [CRD_W-1:0] y_end;
    logic [CRD_W-1:0] b_end;
    logic [3:0]       blit_n;
    logic             x_on;
    logic             y_on;
    t_cmd_desc        desc;

    // stall is set in reset and drops once reset is released; clearing status then holds it so the sweep owns the store
    assign n_stall = 1'b0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stall <= 1'b1;
        end else begin
            r_stall <= n_stall;
        end
    end

    assign o_in_stall  = r_stall || i_q_full || i_status.clearing;
    assign o_push      = i_in_valid && !o_in_stall;
    assign o_push_desc = desc;

    always_comb begin
        x_c    = CRD_W'(i_in_item.x);
        y_c    = CRD_W'(i_in_item.y);
        x_on   = x_c < COLS_C;
        y_on   = y_c < ROWS_C;
        x_end  = x_c + CRD_W'(i_in_item.width) - CRD_W'(1);
        y_end  = y_c + CRD_W'(i_in_item.height) - CRD_W'(1);
        blit_n = (i_in_item.bit_count > BLIT_MAX_BITS) ? BLIT_MAX_BITS : i_in_item.bit_count;
        b_end  = x_c + CRD_W'(blit_n) - CRD_W'(1);

        desc        = '0;
        desc.op     = OP_NOP;
        desc.col_lo = COL_W'(i_in_item.x);
        desc.col_hi = COL_W'(i_in_item.x);
        desc.row_lo = ROW_W'(i_in_item.y);
        desc.row_hi = ROW_W'(i_in_item.y);
        desc.color  = i_in_item.color;
        desc.bits   = i_in_item.bitmap_bits;

        case (i_in_item.cmd)
            CMD_CLEAR: begin
                desc.op = OP_CLEAR;
            end
            CMD_PIXEL: begin
                if (x_on && y_on) begin
                    desc.op = OP_DRAW;
                end
            end
            CMD_FILL: begin
                if (x_on && y_on && i_in_item.width != 8'd0 && i_in_item.height != 8'd0) begin
                    desc.op     = OP_DRAW;
                    desc.col_hi = COL_W'((x_end > COL_MAX) ? COL_MAX : x_end);
                    desc.row_hi = ROW_W'((y_end > ROW_MAX) ? ROW_MAX : y_end);
                end
            end
            CMD_BLIT: begin
                if (x_on && y_on && blit_n != 4'd0) begin
                    desc.op     = OP_BLIT;
                    desc.color  = 1'b1;
                    desc.col_hi = COL_W'((b_end > COL_MAX) ? COL_MAX : b_end);
                end
            end
            CMD_READ: begin
                desc.op     = OP_READ;
                desc.rd_ok  = x_on && (CRD_W'(i_in_item.page) < PAGES_C);
                desc.row_lo = ROW_W'({i_in_item.page, 3'b000});
                desc.row_hi = ROW_W'({i_in_item.page, 3'b000});
            end
            default: begin
                desc.op = OP_NOP;
            end
        endcase
    end

endmodule

@@ design/pfb_queue.sv @@
`timescale 1ns / 1ps
module pfb_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pfb_pkg::t_cmd_desc i_push_desc,
    output logic               o_full,
    input  logic               i_pop,
    output pfb_pkg::t_cmd_desc o_pop_desc,
    output logic               o_empty
);
    import pfb_pkg::*;

    t_cmd_desc              r_slot [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic [QUEUE_PTR_W-1:0] n_wr_ptr;
    logic [QUEUE_PTR_W-1:0] n_rd_ptr;
    logic [QUEUE_CNT_W-1:0] n_count;

    assign o_full     = r_count == QUEUE_CNT_W'(QUEUE_DEPTH);
    assign o_empty    = r_count == '0;
    assign o_pop_desc = r_slot[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

@@ design/pfb_back.sv @@
`timescale 1ns / 1ps
module pfb_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  pfb_pkg::t_cmd_desc    i_q_desc,
    output logic                  o_pop,
    output pfb_pkg::t_back_status o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output pfb_pkg::t_result      o_out_item
);
    import pfb_pkg::*;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_RD   = 3'd3;
    localparam logic [2:0] S_WR   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rdata;
    logic [2:0]        r_state;
    logic [2:0]        n_state;
    t_cmd_desc         r_desc;
    t_cmd_desc         n_desc;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [PAGE_W-1:0] r_page;
    logic [PAGE_W-1:0] n_page;
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] n_addr;
    logic [7:0]        r_bits;
    logic [7:0]        n_bits;
    t_result           r_res;
    t_result           n_res;
    logic              r_out_valid;
    logic              n_out_valid;
    t_result           r_out;
    t_result           n_out;

    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [ADDR_W-1:0] mem_addr;
    logic [ADDR_W-1:0] pc_addr;
    logic [PAGE_W-1:0] page_lo;
    logic [PAGE_W-1:0] page_hi;
    logic [7:0]        mask_lo;
    logic [7:0]        mask_hi;
    logic [7:0]        mask;
    logic              out_free;
    logic              sweep_last;

    assign o_status.clearing = r_state == S_INIT;
    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out;

    assign page_lo = PAGE_W'(r_desc.row_lo >> 3);
    assign page_hi = PAGE_W'(r_desc.row_hi >> 3);
    assign mask_lo = (r_page == page_lo) ? (8'hFF << (r_desc.row_lo[2:0] & PAGE_ROW_MASK))
                                         : 8'hFF;
    assign mask_hi = (r_page == page_hi) ? (8'hFF >> (3'd7 - r_desc.row_hi[2:0])) : 8'hFF;
    assign mask    = mask_lo & mask_hi;

    assign pc_addr    = ADDR_W'(r_page) * ADDR_W'(SCREEN_COLUMNS) + ADDR_W'(r_col);
    assign mem_addr   = (r_state == S_INIT || r_state == S_CLR) ? r_addr : pc_addr;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign sweep_last = r_addr == ADDR_W'(STORE_DEPTH - 1);

    always_comb begin
        n_state     = r_state;
        n_desc      = r_desc;
        n_col       = r_col;
        n_page      = r_page;
        n_addr      = r_addr;
        n_bits      = r_bits;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wdata   = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (sweep_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop  = 1'b1;
                    n_desc = i_q_desc;
                    n_col  = i_q_desc.col_lo;
                    n_page = PAGE_W'(i_q_desc.row_lo >> 3);
                    n_bits = i_q_desc.bits;
                    n_addr = '0;
                    n_res  = '0;
                    case (i_q_desc.op)
                        OP_CLEAR: begin
                            n_state = S_CLR;
                        end
                        OP_DRAW, OP_BLIT: begin
                            n_state = S_RD;
                        end
                        OP_READ: begin
                            n_res.is_read = 1'b1;
                            n_state       = i_q_desc.rd_ok ? S_RD : S_DONE;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CLR: begin
                mem_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (sweep_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                if (r_desc.op == OP_READ) begin
                    n_res.read_data = r_rdata;
                    n_state         = S_DONE;
                end else begin
                    mem_we = 1'b1;
                    if (r_desc.op == OP_BLIT) begin
                        mem_wdata = r_rdata | (mask & {8{r_bits[7]}});
                    end else if (r_desc.color) begin
                        mem_wdata = r_rdata | mask;
                    end else begin
                        mem_wdata = r_rdata & ~mask;
                    end
                    n_bits = r_bits << 1;
                    if (r_col == r_desc.col_hi) begin
                        if (r_page == page_hi) begin
                            n_state = S_DONE;
                        end else begin
                            n_page  = r_page + 1'b1;
                            n_col   = r_desc.col_lo;
                            n_state = S_RD;
                        end
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_state = S_RD;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_desc <= n_desc;
        r_col  <= n_col;
        r_page <= n_page;
        r_bits <= n_bits;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

endmodule

@@ design/pfb_checker.sv @@
`timescale 1ns / 1ps
module pfb_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input pfb_pkg::t_item   i_in_item,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input pfb_pkg::t_result o_out_item
);
    import pfb_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result changed");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.is_read |-> o_out_item.read_data == 8'd0)
        else $error("non-read result carries data");

    a_reset_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken during store sweep");

    a_reset_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown after reset");

endmodule

bind page_frame_buffer_draw_engine_top pfb_checker u_pfb_checker (.*);
